### rtl/core/c5f_pkg.sv
package c5f_pkg;

  localparam int COEF_W   = 12;
  localparam int SAMPLE_W = 8;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int RSUM_W   = PROD_W + 3;
  localparam int SUM_W    = PROD_W + 5;
  localparam int KSIZE    = 5;
  localparam int NCOLOR   = 3;
  localparam int NBANK    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  typedef logic [31:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_CHANNEL = 3'd2,
    REG_KROW0   = 3'd3,
    REG_KROW1   = 3'd4,
    REG_KROW2   = 3'd5,
    REG_KROW3   = 3'd6,
    REG_KROW4   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } pos_t;

  typedef struct packed {
    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;
  } tap_mask_t;

endpackage

### rtl/core/c5f_pix_in_if.sv
interface c5f_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_chan0;
  logic [7:0] in_chan1;
  logic [7:0] in_chan2;
  logic [7:0] in_alpha;

  modport source (output valid, in_chan0, in_chan1, in_chan2, in_alpha, input ready);
  modport sink (input valid, in_chan0, in_chan1, in_chan2, in_alpha, output ready);
endinterface

### rtl/core/c5f_pix_out_if.sv
interface c5f_pix_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_chan0;
  logic [7:0]  out_chan1;
  logic [7:0]  out_chan2;
  logic [7:0]  out_alpha;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        frame_last;

  modport source (output valid, out_chan0, out_chan1, out_chan2, out_alpha, out_row,
                  out_col, frame_last, input ready);
  modport sink (input valid, out_chan0, out_chan1, out_chan2, out_alpha, out_row,
                out_col, frame_last, output ready);
endinterface

### rtl/core/c5f_cfg_if.sv
interface c5f_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [59:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/c5f_ram.sv
module c5f_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/conv5x5_image_filter.sv
// 5x5 convolution filter over a raster pixel stream. Every row is sent with two trailing
// padding columns and every frame with two trailing padding rows, so one frame is
// (height+2)*(width+2) requests; the request at scan position (r,c), r>=2 and c>=2, yields
// output pixel (r-2,c-2), with taps outside the image read as zero. Up to three color
// channels are filtered with signed Q2.10 taps (kernel_row_n holds row offset n-2, bits
// 12k+11:12k the tap at column offset k-2), truncated and clamped to 0..255; with four
// channels alpha is copied from the center pixel. One request is taken per clock unless
// out_if.ready stalls; results pass line-store read, window shift, tap products, row sums,
// final sum and clamp. The four line stores are MAX_WIDTH+2-word RAMs with no reset contents.
// Configuration must be written only while the stream is idle; the block does not enforce it.
module conv5x5_image_filter
  import c5f_pkg::*;
#(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 4096,
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic   clk,
  input  logic   rst_n,
  c5f_pix_in_if.sink    in_if,
  c5f_pix_out_if.source out_if,
  c5f_cfg_if.sink       cfg_if
);

  localparam int LINE_DEPTH = MAX_WIDTH + 2;
  localparam int CW = $clog2(LINE_DEPTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  // configuration
  logic [10:0]           width_r;
  logic [12:0]           height_r;
  logic [2:0]            nch_r;
  logic [CFG_DATA_W-1:0] krow_r [KSIZE];

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1;
      height_r <= 13'd1;
      nch_r    <= 3'd3;
      for (int i = 0; i < KSIZE; i++) begin
        krow_r[i] <= '0;
      end
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_WIDTH:   width_r   <= cfg_if.data[10:0];
        REG_HEIGHT:  height_r  <= cfg_if.data[12:0];
        REG_CHANNEL: nch_r     <= cfg_if.data[2:0];
        REG_KROW0:   krow_r[0] <= cfg_if.data;
        REG_KROW1:   krow_r[1] <= cfg_if.data;
        REG_KROW2:   krow_r[2] <= cfg_if.data;
        REG_KROW3:   krow_r[3] <= cfg_if.data;
        REG_KROW4:   krow_r[4] <= cfg_if.data;
        default: ;
      endcase
    end
  end

  logic [31:0] w_eff, h_eff;
  logic [2:0]  nch_eff;

  always_comb begin
    w_eff = 32'(width_r);
    if (w_eff < 32'd1) w_eff = 32'd1;
    if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    h_eff = 32'(height_r);
    if (h_eff < 32'd1) h_eff = 32'd1;
    if (h_eff > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
    nch_eff = nch_r;
    if (nch_eff < 3'd1) nch_eff = 3'd1;
    if (nch_eff > 3'd4) nch_eff = 3'd4;
  end

  // stage handshakes
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic e1, e2, e3, e4, e5, acc;

  assign e5 = !v5_r || out_if.ready;
  assign e4 = !v4_r || e5;
  assign e3 = !v3_r || e4;
  assign e2 = !v2_r || e3;
  assign e1 = !v1_r || e2;
  assign in_if.ready = e1;
  assign acc = in_if.valid && e1;

  // scan position and request decode
  logic [RW-1:0] scan_row_r, scan_row_nxt;
  logic [CW-1:0] scan_col_r, scan_col_nxt;
  logic [31:0]   r32, c32;
  pixel_t        pix0;
  logic          emit0;
  pos_t          pos0;
  tap_mask_t     mask0;

  always_comb begin
    r32 = 32'(scan_row_r);
    c32 = 32'(scan_col_r);
    pix0 = '0;
    if (r32 < h_eff && c32 < w_eff) begin
      pix0 = {in_if.in_alpha, in_if.in_chan2, in_if.in_chan1, in_if.in_chan0};
    end
    emit0 = r32 >= 32'd2 && c32 >= 32'd2 && (r32 - 32'd2) < h_eff && (c32 - 32'd2) < w_eff;
    pos0.row  = 12'(r32 - 32'd2);
    pos0.col  = 10'(c32 - 32'd2);
    pos0.last = (r32 == h_eff + 32'd1) && (c32 == w_eff + 32'd1);
    for (int j = 0; j < KSIZE; j++) begin
      mask0.row_ok[j] = !((r32 + 32'(j) < 32'd4) || (r32 + 32'(j) >= h_eff + 32'd4));
      mask0.col_ok[j] = !((c32 + 32'(j) < 32'd4) || (c32 + 32'(j) >= w_eff + 32'd4));
    end
    if (c32 >= w_eff + 32'd1) begin
      scan_col_nxt = '0;
      scan_row_nxt = (r32 >= h_eff + 32'd1) ? '0 : RW'(r32 + 32'd1);
    end else begin
      scan_col_nxt = CW'(c32 + 32'd1);
      scan_row_nxt = scan_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r <= '0;
      scan_col_r <= '0;
    end else if (acc) begin
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
    end
  end

  // line stores
  pixel_t ram_rd [NBANK];

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    c5f_ram #(
      .WIDTH(32),
      .DEPTH(LINE_DEPTH)
    ) u_line (
      .clk   (clk),
      .we    (acc && (scan_row_r[1:0] == 2'(b))),
      .waddr (scan_col_r),
      .wdata (pix0),
      .re    (e1),
      .raddr (scan_col_r),
      .rdata (ram_rd[b])
    );
  end

  // stage 1: line-store data arrives
  logic      emit1_r;
  logic [1:0] rsel1_r;
  pixel_t    pix1_r;
  pos_t      pos1_r;
  tap_mask_t mask1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (e1) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      emit1_r <= emit0;
      rsel1_r <= scan_row_r[1:0];
      pix1_r  <= pix0;
      pos1_r  <= pos0;
      mask1_r <= mask0;
    end
  end

  // stage 2: window shift
  pixel_t    win_r [KSIZE][KSIZE];
  pixel_t    colv [KSIZE];
  pos_t      pos2_r;
  tap_mask_t mask2_r;

  always_comb begin
    for (int j = 0; j < NBANK; j++) begin
      colv[j] = ram_rd[2'(rsel1_r + 2'(j))];
    end
    colv[KSIZE-1] = pix1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      for (int j = 0; j < KSIZE; j++) begin
        for (int k = 0; k < KSIZE; k++) begin
          win_r[j][k] <= '0;
        end
      end
    end else if (e2) begin
      v2_r <= v1_r && emit1_r;
      if (v1_r) begin
        for (int j = 0; j < KSIZE; j++) begin
          for (int k = 0; k < KSIZE - 1; k++) begin
            win_r[j][k] <= win_r[j][k+1];
          end
          win_r[j][KSIZE-1] <= colv[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      pos2_r  <= pos1_r;
      mask2_r <= mask1_r;
    end
  end

  // stage 3: tap products
  logic signed [PROD_W-1:0] prod_r [NCOLOR][KSIZE][KSIZE];
  logic signed [PROD_W-1:0] prod_nxt [NCOLOR][KSIZE][KSIZE];
  logic [7:0] alpha3_r;
  pos_t       pos3_r;

  always_comb begin
    logic signed [COEF_W-1:0] coef;
    logic signed [8:0]        samp;
    for (int ch = 0; ch < NCOLOR; ch++) begin
      for (int j = 0; j < KSIZE; j++) begin
        for (int k = 0; k < KSIZE; k++) begin
          coef = krow_r[j][COEF_W*k +: COEF_W];
          samp = $signed({1'b0, win_r[j][k][8*ch +: 8]});
          if (mask2_r.row_ok[j] && mask2_r.col_ok[k] && (3'(ch) < nch_eff)) begin
            prod_nxt[ch][j][k] = PROD_W'(coef) * PROD_W'(samp);
          end else begin
            prod_nxt[ch][j][k] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (e3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e3) begin
      prod_r   <= prod_nxt;
      alpha3_r <= (nch_eff == 3'd4) ? win_r[2][2][31:24] : 8'd0;
      pos3_r   <= pos2_r;
    end
  end

  // stage 4: row sums
  logic signed [RSUM_W-1:0] rsum_r [NCOLOR][KSIZE];
  logic signed [RSUM_W-1:0] rsum_nxt [NCOLOR][KSIZE];
  logic [7:0] alpha4_r;
  pos_t       pos4_r;

  always_comb begin
    for (int ch = 0; ch < NCOLOR; ch++) begin
      for (int j = 0; j < KSIZE; j++) begin
        rsum_nxt[ch][j] = '0;
        for (int k = 0; k < KSIZE; k++) begin
          rsum_nxt[ch][j] = rsum_nxt[ch][j] + RSUM_W'(prod_r[ch][j][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (e4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e4) begin
      rsum_r   <= rsum_nxt;
      alpha4_r <= alpha3_r;
      pos4_r   <= pos3_r;
    end
  end

  // stage 5: total, clamp, result register
  logic signed [SUM_W-1:0] tot [NCOLOR];
  logic [SUM_W-1:0]        q [NCOLOR];
  logic [7:0]              res_nxt [NCOLOR];
  logic [7:0]              res_r [NCOLOR];
  logic [7:0]              alpha5_r;
  pos_t                    pos5_r;

  always_comb begin
    for (int ch = 0; ch < NCOLOR; ch++) begin
      tot[ch] = '0;
      for (int j = 0; j < KSIZE; j++) begin
        tot[ch] = tot[ch] + SUM_W'(rsum_r[ch][j]);
      end
      q[ch] = SUM_W'(tot[ch]) >> COEF_FRAC_BITS;
      if (tot[ch] <= 0) begin
        res_nxt[ch] = 8'd0;
      end else if (q[ch] > SUM_W'(255)) begin
        res_nxt[ch] = 8'd255;
      end else begin
        res_nxt[ch] = q[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (e5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e5) begin
      res_r    <= res_nxt;
      alpha5_r <= alpha4_r;
      pos5_r   <= pos4_r;
    end
  end

  assign out_if.valid      = v5_r;
  assign out_if.out_chan0  = res_r[0];
  assign out_if.out_chan1  = res_r[1];
  assign out_if.out_chan2  = res_r[2];
  assign out_if.out_alpha  = alpha5_r;
  assign out_if.out_row    = pos5_r.row;
  assign out_if.out_col    = pos5_r.col;
  assign out_if.frame_last = pos5_r.last;

  a_ready_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (v1_r && v2_r && v3_r && v4_r && v5_r && !out_if.ready))
    else $error("input stalled with room in the pipeline");

  a_scan_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_col_r) <= 32'(MAX_WIDTH) + 32'd1)
    else $error("scan column past line store");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid && scan_row_r == '0 && scan_col_r == '0)
    else $error("reset did not clear pipeline");

endmodule
